// ----- hw/rtl/uer_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int TimeoutW = 16;
	localparam int ThreshW  = 16;
	localparam int DistW    = 14;
	localparam int AddrW    = 3;

	localparam logic [TimeoutW-1:0] TimeoutReset = 16'd30000;
	localparam logic [ThreshW-1:0]  ThreshReset  = 16'd300;

	localparam int TriggerHighTicksDef = 12;
	localparam int TriggerLowTicksDef  = 2;

	// floor(n * 343 / 2000) == (n * DistRecip) >> DistShift for any 16-bit n
	localparam logic [31:0] DistRecip = 32'd736586892;
	localparam int          DistShift = 32;

	typedef enum logic {
		REG_TIMEOUT   = 1'b0,
		REG_THRESHOLD = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_TLOW    = 5'b00010,
		PH_THIGH   = 5'b00100,
		PH_WAIT    = 5'b01000,
		PH_MEASURE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [TimeoutW-1:0] echo_limit;
		logic [ThreshW-1:0]  obstacle_threshold_mm;
	} cfg_t;

endpackage

// ----- hw/rtl/uer_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_in_if / uer_out_if
// Valid/ready channels for tick items and ranging results.
// ----------------------------------------------------------------------------
interface uer_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic echo_level;

	modport source (output valid, cmd, echo_level, input ready);
	modport sink   (input valid, cmd, echo_level, output ready);
endinterface

interface uer_out_if;
	import uer_pkg::*;

	logic             valid;
	logic             ready;
	logic             trigger;
	logic             busy_res;
	logic             done_res;
	logic             ok;
	logic [TimeoutW-1:0] echo_us;
	logic [DistW-1:0] distance_mm;
	logic             obstacle;

	modport source (output valid, trigger, busy_res, done_res, ok, echo_us, distance_mm,
		obstacle, input ready);
	modport sink   (input valid, trigger, busy_res, done_res, ok, echo_us, distance_mm,
		obstacle, output ready);
endinterface

// ----- hw/rtl/uer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_core
// Trigger/echo sequencer: input register, one-tick state update, result
// register.
// ----------------------------------------------------------------------------
module uer_core #(
	parameter int TRIGGER_HIGH_TICKS = uer_pkg::TriggerHighTicksDef,
	parameter int TRIGGER_LOW_TICKS  = uer_pkg::TriggerLowTicksDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  uer_pkg::cfg_t cfg,
	uer_in_if.sink        in_ch,
	uer_out_if.source     out_ch
);
	import uer_pkg::*;

	localparam logic [TimeoutW-1:0] HighTicks = TimeoutW'(TRIGGER_HIGH_TICKS);
	localparam logic [TimeoutW-1:0] LowTicks  = TimeoutW'(TRIGGER_LOW_TICKS);

	logic                v_s1;
	logic                cmd_s1;
	logic                echo_s1;
	logic                advance;

	phase_t              phase_q;
	logic [TimeoutW-1:0] cnt_q;
	logic [TimeoutW-1:0] echo_time_q;
	logic [DistW-1:0]    dist_q;
	logic                ok_q;
	logic                out_valid_q;

	phase_t              phase_n;
	logic [TimeoutW-1:0] cnt_n;
	logic [TimeoutW-1:0] cnt_inc;
	logic [TimeoutW-1:0] echo_time_n;
	logic [DistW-1:0]    dist_n;
	logic                ok_n;
	logic                trig_n;
	logic                done_n;
	logic [47:0]         prod;

	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !v_s1 || advance;
	assign out_ch.valid = out_valid_q;

	assign prod = 48'(cnt_q) * 48'(DistRecip);

	always_comb begin
		phase_n     = phase_q;
		cnt_n       = cnt_q;
		echo_time_n = echo_time_q;
		dist_n      = dist_q;
		ok_n        = ok_q;
		trig_n      = 1'b0;
		done_n      = 1'b0;
		if (phase_q == PH_IDLE && cmd_s1) begin
			ok_n    = 1'b0;
			phase_n = PH_TLOW;
			cnt_n   = '0;
		end
		cnt_inc = cnt_n + TimeoutW'(1);
		case (phase_n)
			PH_IDLE: begin
			end
			PH_TLOW: begin
				cnt_n = cnt_inc;
				if (cnt_inc >= LowTicks) begin
					phase_n = PH_THIGH;
					cnt_n   = '0;
				end
			end
			PH_THIGH: begin
				trig_n = 1'b1;
				cnt_n  = cnt_inc;
				if (cnt_inc >= HighTicks) begin
					phase_n = PH_WAIT;
					cnt_n   = '0;
				end
			end
			PH_WAIT: begin
				if (!echo_s1) begin
					if (cnt_q >= cfg.echo_limit) begin
						echo_time_n = '0;
						dist_n      = '0;
						ok_n        = 1'b0;
						phase_n     = PH_IDLE;
						cnt_n       = '0;
						done_n      = 1'b1;
					end else begin
						cnt_n = cnt_inc;
					end
				end else if (cfg.echo_limit == '0) begin
					// rising tick already at the width limit
					echo_time_n = '0;
					dist_n      = '0;
					ok_n        = 1'b0;
					phase_n     = PH_IDLE;
					cnt_n       = '0;
					done_n      = 1'b1;
				end else begin
					// rising tick counts as the first high tick
					phase_n = PH_MEASURE;
					cnt_n   = TimeoutW'(1);
				end
			end
			PH_MEASURE: begin
				if (echo_s1) begin
					if (cnt_q >= cfg.echo_limit) begin
						echo_time_n = cnt_q;
						dist_n      = '0;
						ok_n        = 1'b0;
						phase_n     = PH_IDLE;
						cnt_n       = '0;
						done_n      = 1'b1;
					end else begin
						cnt_n = cnt_inc;
					end
				end else begin
					echo_time_n = cnt_q;
					dist_n      = prod[DistShift +: DistW];
					ok_n        = 1'b1;
					phase_n     = PH_IDLE;
					cnt_n       = '0;
					done_n      = 1'b1;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				cnt_n   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_s1  <= in_ch.cmd;
			echo_s1 <= in_ch.echo_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			echo_time_q <= '0;
			dist_q      <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (v_s1 && advance) begin
			phase_q     <= phase_n;
			cnt_q       <= cnt_n;
			echo_time_q <= echo_time_n;
			dist_q      <= dist_n;
			ok_q        <= ok_n;
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: hold while the sink stalls
	always_ff @(posedge clk) begin
		if (v_s1 && advance) begin
			out_ch.trigger     <= trig_n;
			out_ch.busy_res    <= (phase_n != PH_IDLE);
			out_ch.done_res    <= done_n;
			out_ch.ok          <= ok_n;
			out_ch.echo_us     <= echo_time_n;
			out_ch.distance_mm <= dist_n;
			out_ch.obstacle    <= ok_n && (ThreshW'(dist_n) <= cfg.obstacle_threshold_mm);
		end
	end

endmodule

// ----- hw/rtl/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Ultrasonic range controller: one tick item in, one result item out.
// ----------------------------------------------------------------------------
// Path: the tick is taken into the input register at the transfer edge, then
//   into the result register once the result sink can take it; the whole tick
//   update sits between the two.
// Throughput: one tick per cycle while the result sink does not stall; a stalled
//   result register backs up only through the single input stage.
// Reset: arst_n clears the sequencer to idle, stored results to zero and the
//   registers to timeout 30000 us and threshold 300 mm.
module ultrasonic_echo_ranger #(
	parameter int TRIGGER_HIGH_TICKS = uer_pkg::TriggerHighTicksDef,
	parameter int TRIGGER_LOW_TICKS  = uer_pkg::TriggerLowTicksDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	uer_in_if.sink                   in_ch,
	uer_out_if.source                out_ch,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [uer_pkg::AddrW-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	import uer_pkg::*;

	logic [TimeoutW-1:0] timeout_q;
	logic [ThreshW-1:0]  thresh_q;
	reg_idx_t            reg_idx;
	logic                wr_en;
	cfg_t                cfg;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
			thresh_q  <= ThreshReset;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TIMEOUT:   timeout_q <= pwdata[TimeoutW-1:0];
				REG_THRESHOLD: thresh_q  <= pwdata[ThreshW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TIMEOUT:   prdata = 32'(timeout_q);
			REG_THRESHOLD: prdata = 32'(thresh_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.echo_limit            = timeout_q;
	assign cfg.obstacle_threshold_mm = thresh_q;

	uer_core #(
		.TRIGGER_HIGH_TICKS (TRIGGER_HIGH_TICKS),
		.TRIGGER_LOW_TICKS  (TRIGGER_LOW_TICKS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// ----- hw/rtl/uer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks on the ranger result channel.
// ----------------------------------------------------------------------------
module uer_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     trigger,
	input logic                     busy_res,
	input logic                     done_res,
	input logic                     ok,
	input logic [uer_pkg::DistW-1:0] distance_mm,
	input logic                     obstacle
);

	// a stalled result must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_mm) && $stable(done_res))
		else $error("result changed while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("busy set on the finishing tick");

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger |-> busy_res && !done_res)
		else $error("trigger high outside a sequence");

	a_obst_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && obstacle |-> ok)
		else $error("obstacle without a good measurement");

	a_fail_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res && !ok |-> distance_mm == '0)
		else $error("failed measurement left a distance");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.trigger     (out_ch.trigger),
	.busy_res    (out_ch.busy_res),
	.done_res    (out_ch.done_res),
	.ok          (out_ch.ok),
	.distance_mm (out_ch.distance_mm),
	.obstacle    (out_ch.obstacle)
);
